[rtl/arw_pkg.sv]
// shared constants, codes and state type for the anti-replay window unit
package arw_pkg;

  // bitmap storage word and the bit-offset field inside it
  localparam int ARW_WORD_BITS   = 64;
  localparam int ARW_BIT_SEL_W   = 6;
  localparam int ARW_ID_W        = 64;
  localparam int ARW_WINDOW_BITS = 1024;

  // command codes
  localparam logic CMD_CHECK  = 1'b0;
  localparam logic CMD_COMMIT = 1'b1;

  // status codes
  localparam logic STAT_FRESH  = 1'b0;
  localparam logic STAT_REPLAY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CHK_RD,
    S_CHK_BIT,
    S_RESULT,
    S_SLIDE,
    S_SET_RD,
    S_SET_WR
  } arw_state_t;

endpackage

[rtl/anti_replay_window_unit.sv]
// anti-replay sliding window: highest-id register and a bitmap in a synchronous memory
// an in-window check goes through decode, read, bit pick and result; any other check through
//   decode and result; a stall on the output holds the answer in the result state
// in_stall is high while the unit is not idle, so a new command is taken only after the last
//   one is done; a sliding commit streams the words through the one read and one write port
// reset (rst_n low, synchronous): highest id to zero, bitmap words flagged empty at once
module anti_replay_window_unit
  import arw_pkg::*;
#(
  parameter int WINDOW_BITS = ARW_WINDOW_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_cmd,
  input  logic [ARW_ID_W-1:0] in_packet_id,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_status
);

  // bitmap geometry
  localparam int NW  = (WINDOW_BITS + ARW_WORD_BITS - 1) / ARW_WORD_BITS;
  localparam int WI  = (NW > 1) ? $clog2(NW) : 1;
  localparam int OFW = WI + ARW_BIT_SEL_W;

  localparam logic [WI-1:0] TOP_IDX = WI'(NW - 1);
  localparam logic [ARW_ID_W-1:0] WIN_LIMIT = ARW_ID_W'(WINDOW_BITS);

  // fsm
  arw_state_t state_r, state_nxt;

  // accepted word
  logic                cmd_r;
  logic [ARW_ID_W-1:0] id_r;

  // window head
  logic [ARW_ID_W-1:0] hi_r, hi_nxt;

  // offset of the bit to test or set, and the slide distance
  logic [OFW-1:0] off_r, off_nxt;
  logic [OFW-1:0] sh_r, sh_nxt;

  // check answer waiting for the output register
  logic res_r, res_nxt;

  // slide sequencer
  logic [WI-1:0]            rd_idx_r, rd_idx_nxt;   // next source word to read
  logic [WI-1:0]            wr_idx_r, wr_idx_nxt;   // next destination word to write
  logic                     rd_more_r, rd_more_nxt; // source reads still to issue
  logic                     pend_r, pend_nxt;       // read data arrives this cycle
  logic                     hprev_r, hprev_nxt;     // prev_r holds the upper source word
  logic [ARW_WORD_BITS-1:0] prev_r, prev_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic out_status_r, out_status_nxt;

  // bitmap memory, one read and one write port, registered read
  logic [ARW_WORD_BITS-1:0] mem [NW];
  logic [NW-1:0]            vld_r;
  logic                     vld_q;
  logic [ARW_WORD_BITS-1:0] rd_q;
  logic                     mem_re;
  logic [WI-1:0]            mem_ra;
  logic                     mem_we;
  logic [WI-1:0]            mem_wa;
  logic [ARW_WORD_BITS-1:0] mem_wd;
  logic                     vld_clr;
  logic [ARW_WORD_BITS-1:0] rdata;

  // decode of the accepted word against the window head
  logic [ARW_ID_W:0]    up_full;
  logic [ARW_ID_W-1:0]  diff_up;
  logic [ARW_ID_W-1:0]  diff_dn;
  logic                 id_gt;
  logic                 up_in_win;
  logic                 dn_in_win;

  // slide data path
  logic [ARW_BIT_SEL_W-1:0] bsh;
  logic [ARW_BIT_SEL_W-1:0] bsh_inv;
  logic [ARW_WORD_BITS-1:0] lo_word;
  logic [ARW_WORD_BITS-1:0] slide_word;
  logic                     result_go;

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  // result register is free when empty or being drained this cycle
  assign result_go = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------------------
  // compare and distance, both directions in parallel
  // ---------------------------------------------------------------------------
  assign up_full   = {1'b0, id_r} - {1'b0, hi_r};
  assign diff_up   = up_full[ARW_ID_W-1:0];
  assign id_gt     = !up_full[ARW_ID_W] && (diff_up != '0);
  assign diff_dn   = hi_r - id_r;
  assign up_in_win = (diff_up < WIN_LIMIT);
  assign dn_in_win = (diff_dn < WIN_LIMIT);

  // empty words read as zero
  assign rdata = vld_q ? rd_q : '0;

  // slide: new[d] = old[s] << bsh | old[s-1] >> (64 - bsh), s = d - wsh
  assign bsh        = sh_r[ARW_BIT_SEL_W-1:0];
  assign bsh_inv    = ARW_BIT_SEL_W'(7'd64 - {1'b0, bsh});
  assign lo_word    = pend_r ? rdata : '0;
  assign slide_word = (prev_r << bsh) | ((bsh == '0) ? '0 : (lo_word >> bsh_inv));

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (cmd_r == CMD_CHECK) begin
          if (id_gt || !dn_in_win) begin
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_CHK_RD;
          end
        end else if (id_gt) begin
          // a jump past the window empties it, a shorter one slides it
          state_nxt = up_in_win ? S_SLIDE : S_SET_RD;
        end else begin
          state_nxt = dn_in_win ? S_SET_RD : S_IDLE;
        end
      end
      S_CHK_RD:  state_nxt = S_CHK_BIT;
      S_CHK_BIT: state_nxt = S_RESULT;
      S_RESULT: begin
        if (result_go) begin
          state_nxt = S_IDLE;
        end
      end
      S_SLIDE: begin
        // done once word zero has been written
        if (mem_we && (wr_idx_r == '0)) begin
          state_nxt = S_SET_RD;
        end
      end
      S_SET_RD: state_nxt = S_SET_WR;
      S_SET_WR: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // outputs and data path controls
  // ---------------------------------------------------------------------------
  always_comb begin
    hi_nxt         = hi_r;
    off_nxt        = off_r;
    sh_nxt         = sh_r;
    res_nxt        = res_r;
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    rd_more_nxt    = rd_more_r;
    pend_nxt       = 1'b0;
    hprev_nxt      = hprev_r;
    prev_nxt       = prev_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    mem_re         = 1'b0;
    mem_ra         = off_r[OFW-1:ARW_BIT_SEL_W];
    mem_we         = 1'b0;
    mem_wa         = off_r[OFW-1:ARW_BIT_SEL_W];
    mem_wd         = '0;
    vld_clr        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
      end
      S_DECODE: begin
        if (cmd_r == CMD_CHECK) begin
          if (id_gt) begin
            res_nxt = STAT_FRESH;
          end else if (!dn_in_win) begin
            res_nxt = STAT_REPLAY;
          end else begin
            off_nxt = diff_dn[OFW-1:0];
          end
        end else if (id_gt) begin
          hi_nxt  = id_r;
          off_nxt = '0;
          if (up_in_win) begin
            sh_nxt      = diff_up[OFW-1:0];
            rd_idx_nxt  = TOP_IDX - diff_up[OFW-1:ARW_BIT_SEL_W];
            wr_idx_nxt  = TOP_IDX;
            rd_more_nxt = 1'b1;
            hprev_nxt   = 1'b0;
          end else begin
            vld_clr = 1'b1;
          end
        end else begin
          off_nxt = diff_dn[OFW-1:0];
        end
      end
      S_CHK_RD: begin
        mem_re = 1'b1;
      end
      S_CHK_BIT: begin
        res_nxt = rdata[off_r[ARW_BIT_SEL_W-1:0]];
      end
      S_RESULT: begin
        if (result_go) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
        end
      end
      S_SLIDE: begin
        // source reads walk down from the top source word
        if (rd_more_r) begin
          mem_re   = 1'b1;
          mem_ra   = rd_idx_r;
          pend_nxt = 1'b1;
          if (rd_idx_r == '0) begin
            rd_more_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r - 1'b1;
          end
        end
        if (hprev_r) begin
          // upper source word in hand, lower one arriving (or zero below word 0)
          mem_we     = 1'b1;
          mem_wa     = wr_idx_r;
          mem_wd     = slide_word;
          wr_idx_nxt = wr_idx_r - 1'b1;
          prev_nxt   = rdata;
          hprev_nxt  = pend_r;
        end else if (pend_r) begin
          prev_nxt  = rdata;
          hprev_nxt = 1'b1;
        end else if (!rd_more_r) begin
          // words below the shifted data become empty
          mem_we     = 1'b1;
          mem_wa     = wr_idx_r;
          mem_wd     = '0;
          wr_idx_nxt = wr_idx_r - 1'b1;
        end
      end
      S_SET_RD: begin
        mem_re = 1'b1;
      end
      S_SET_WR: begin
        mem_we = 1'b1;
        mem_wd = rdata | (ARW_WORD_BITS'(1) << off_r[ARW_BIT_SEL_W-1:0]);
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hi_r        <= '0;
      out_valid_r <= 1'b0;
      rd_more_r   <= 1'b0;
      pend_r      <= 1'b0;
      hprev_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hi_r        <= hi_nxt;
      out_valid_r <= out_valid_nxt;
      rd_more_r   <= rd_more_nxt;
      pend_r      <= pend_nxt;
      hprev_r     <= hprev_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r <= in_cmd;
      id_r  <= in_packet_id;
    end
    off_r        <= off_nxt;
    sh_r         <= sh_nxt;
    res_r        <= res_nxt;
    rd_idx_r     <= rd_idx_nxt;
    wr_idx_r     <= wr_idx_nxt;
    prev_r       <= prev_nxt;
    out_status_r <= out_status_nxt;
  end

  // ---------------------------------------------------------------------------
  // bitmap memory and word valid flags
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q  <= mem[mem_ra];
      vld_q <= vld_r[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (vld_clr) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[mem_wa] <= 1'b1;
    end
  end

endmodule
